@@ rtl/sfm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants of the symmetric 11-tap line filter
// Sizes, register indexes and the job record passed from front to back end.
// ----------------------------------------------------------------------------
package sfm_pkg;

  // Filter geometry
  localparam int TAPS      = 11;
  localparam int HALF_TAPS = 5;
  localparam int NUM_COEF  = HALF_TAPS + 1;
  localparam int DIST_W    = $clog2(TAPS);

  // Data widths
  localparam int PIX_W          = 8;
  localparam int PAIR_W         = PIX_W + 1;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int PROD_W         = COEF_W + PAIR_W + 1;
  localparam int RAW_W          = 28;

  // Line bookkeeping
  localparam int MAX_LINE = 1024;
  localparam int LEN_W    = 11;
  localparam int POS_W    = $clog2(MAX_LINE);
  localparam int PC_W     = 4;
  localparam int J_W      = 3;

  // Job queue between front and back end
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTRE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF4   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF5   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd6;

  localparam logic [COEF_W-1:0] COEF_ONE       = COEF_W'(1 << COEF_FRAC_BITS);
  localparam logic [LEN_W-1:0]  LINE_LEN_RESET = LEN_W'(512);

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEF-1:0] coef_arr_t;

  // One output to compute: centre sample and pre-added mirror pairs
  typedef struct packed {
    logic                               last;
    logic [HALF_TAPS-1:0][PAIR_W-1:0]   pairs;   // pairs[a-1] goes with coef a
    logic [PIX_W-1:0]                   centre;
  } job_t;

endpackage : sfm_pkg
`default_nettype wire

@@ rtl/sfm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_front: input acceptance, sample window and job builder
// Keeps the 11-sample window and line position, classifies each pixel and
// turns it into zero, one or a flush run of filter jobs with the taps folded.
// ----------------------------------------------------------------------------
module sfm_front import sfm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] in_pixel_in,
  input  wire logic             in_line_end,
  input  wire logic [LEN_W-1:0] line_length,
  input  wire logic             q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  logic [PIX_W-1:0]  window_r [TAPS];
  logic [POS_W-1:0]  pos_r;
  logic              task_valid_r;
  logic              task_flush_r;
  logic [PC_W-1:0]   task_pc_r;
  logic [J_W-1:0]    task_j_r;

  logic              accept;
  logic              task_final;
  logic              item_end;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  pos_inc;
  logic [DIST_W-1:0] tap_d [TAPS];

  // Distance back from the newest sample to tap i of job j (mirrored, clamped)
  function automatic logic [DIST_W-1:0] tap_dist(input logic [PC_W-1:0] pc,
                                                 input logic [J_W-1:0]  j,
                                                 input logic [3:0]      i);
    logic signed [6:0] p;
    logic signed [6:0] m;
    logic signed [6:0] k;
    logic signed [6:0] d;
    p = $signed({3'b000, pc});
    m = p - ($signed({4'b0000, j}) + 7'sd5 - $signed({3'b000, i}));
    k = (m < 7'sd0) ? -m : m;
    if (k > p) begin
      k = (p <<< 1) - k;
    end
    if (k < 7'sd0) begin
      k = 7'sd0;
    end
    d = p - k;
    if (d < 7'sd0) begin
      d = 7'sd0;
    end
    if (d > 7'sd10) begin
      d = 7'sd10;
    end
    return d[DIST_W-1:0];
  endfunction

  // Classify the incoming pixel
  always_comb begin
    eff_len = line_length;
    if (line_length == '0 || line_length > LEN_W'(MAX_LINE)) begin
      eff_len = LEN_W'(MAX_LINE);
    end
    pos_inc  = {{(LEN_W-POS_W){1'b0}}, pos_r} + LEN_W'(1);
    item_end = in_line_end || (pos_inc >= eff_len);
  end

  // Handshake with the input and the queue
  assign task_final = !task_flush_r || (task_j_r == '0);
  assign q_push     = task_valid_r && !q_full;
  assign in_ready   = !task_valid_r || (q_push && task_final);
  assign accept     = in_valid && in_ready;

  // Fold the taps and pre-add the mirror pairs
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      tap_d[i] = tap_dist(task_pc_r, task_j_r, 4'(i));
    end
    q_job.centre = window_r[tap_d[HALF_TAPS]];
    for (int a = 1; a <= HALF_TAPS; a++) begin
      q_job.pairs[a-1] = {1'b0, window_r[tap_d[HALF_TAPS-a]]}
                       + {1'b0, window_r[tap_d[HALF_TAPS+a]]};
    end
    q_job.last = task_flush_r && (task_j_r == '0);
  end

  // Advance window, position and the pending job run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        window_r[i] <= '0;
      end
      pos_r        <= '0;
      task_valid_r <= 1'b0;
      task_flush_r <= 1'b0;
      task_pc_r    <= '0;
      task_j_r     <= '0;
    end else if (accept) begin
      window_r[0] <= in_pixel_in;
      for (int i = 1; i < TAPS; i++) begin
        window_r[i] <= window_r[i-1];
      end
      pos_r        <= item_end ? '0 : pos_inc[POS_W-1:0];
      task_valid_r <= item_end || (pos_r >= POS_W'(HALF_TAPS));
      task_flush_r <= item_end;
      task_pc_r    <= (pos_r > POS_W'(15)) ? PC_W'(15) : pos_r[PC_W-1:0];
      if (item_end && pos_r < POS_W'(HALF_TAPS)) begin
        task_j_r <= pos_r[J_W-1:0];
      end else begin
        task_j_r <= J_W'(HALF_TAPS);
      end
    end else if (q_push) begin
      if (task_final) begin
        task_valid_r <= 1'b0;
      end else begin
        task_j_r <= task_j_r - J_W'(1);
      end
    end
  end

endmodule : sfm_front
`default_nettype wire

@@ rtl/sfm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_queue: job queue between front and back end
// Small first-in first-out buffer so each side can stall on its own.
// ----------------------------------------------------------------------------
module sfm_queue import sfm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule : sfm_queue
`default_nettype wire

@@ rtl/sfm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_back: multiply-accumulate pipeline and output register
// Six coefficient lanes, a two-level adder tree, then rounding and clipping
// into the output register. The whole pipe holds while a result waits.
// ----------------------------------------------------------------------------
module sfm_back import sfm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire coef_arr_t         coef,
  input  wire logic              q_valid,
  input  wire job_t              q_job,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [RAW_W-1:0] out_filtered_raw,
  output logic [PIX_W-1:0]       out_filtered_pixel,
  output logic                   out_last
);

  localparam int SHR_W = RAW_W - COEF_FRAC_BITS;

  logic                     adv;
  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic signed [PROD_W-1:0] s1_prod_r [NUM_COEF];
  logic                     s2_valid_r;
  logic                     s2_last_r;
  logic signed [RAW_W-1:0]  s2_part_r [3];
  logic                     s3_valid_r;
  logic                     s3_last_r;
  logic signed [RAW_W-1:0]  s3_sum_r;
  logic                     out_valid_r;
  logic                     out_last_r;
  logic signed [RAW_W-1:0]  out_raw_r;
  logic [PIX_W-1:0]         out_pixel_r;
  logic [PIX_W-1:0]         pixel_nxt;
  logic [RAW_W-1:0]         rounded;
  logic [SHR_W-1:0]         scaled;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = q_valid && adv;

  // Round half up, clip to the pixel range
  always_comb begin
    rounded = s3_sum_r + RAW_W'(1 << (COEF_FRAC_BITS - 1));
    scaled  = rounded[RAW_W-1:COEF_FRAC_BITS];
    if (s3_sum_r[RAW_W-1]) begin
      pixel_nxt = '0;
    end else if (scaled > SHR_W'(255)) begin
      pixel_nxt = PIX_W'(255);
    end else begin
      pixel_nxt = scaled[PIX_W-1:0];
    end
  end

  // Control of the pipeline stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Multiply, add and round the data
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r    <= q_job.last;
      s1_prod_r[0] <= $signed(coef[0]) * $signed({2'b00, q_job.centre});
      for (int a = 1; a < NUM_COEF; a++) begin
        s1_prod_r[a] <= $signed(coef[a]) * $signed({1'b0, q_job.pairs[a-1]});
      end
      s2_last_r    <= s1_last_r;
      for (int g = 0; g < 3; g++) begin
        s2_part_r[g] <= RAW_W'(s1_prod_r[2*g]) + RAW_W'(s1_prod_r[2*g+1]);
      end
      s3_last_r    <= s2_last_r;
      s3_sum_r     <= s2_part_r[0] + s2_part_r[1] + s2_part_r[2];
      out_last_r   <= s3_last_r;
      out_raw_r    <= s3_sum_r;
      out_pixel_r  <= pixel_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_raw   = out_raw_r;
  assign out_filtered_pixel = out_pixel_r;
  assign out_last           = out_last_r;

endmodule : sfm_back
`default_nettype wire

@@ rtl/symmetric_fir11_mirror_line_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_fir11_mirror_line_core: 11-tap symmetric line filter
// Row filter with mirrored line edges, six programmable Q2.14 coefficients,
// raw sum and rounded, clipped pixel out.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid/in_ready    in_pixel_in, in_line_end
//  out_     output     out_valid/out_ready  out_filtered_raw, out_filtered_pixel,
//                                           out_last
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Accepts one pixel per cycle while the job queue is not full. The pixel ending a
//  line blocks the input while the job builder issues its flush run.
//  A result passes the queue, multiply, two adder levels, then rounding into
//  the output register.
//  out_ready low holds the back end; the four-entry job queue absorbs it.
//  Reset is synchronous; the window clears at once, there is no clearing pass.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module symmetric_fir11_mirror_line_core import sfm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  input  wire logic                  in_line_end,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [RAW_W-1:0]    out_filtered_raw,
  output logic [PIX_W-1:0]           out_filtered_pixel,
  output logic                       out_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

  coef_arr_t        coef_r;
  logic [LEN_W-1:0] line_len_r;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  job_t             push_job;
  job_t             head_job;

  assign cfg_ready = 1'b1;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r     <= {{(NUM_COEF-1){COEF_W'(0)}}, COEF_ONE};
      line_len_r <= LINE_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index inside {[REG_COEF_CENTRE:REG_COEF_OFF5]}) begin
        coef_r[cfg_index] <= cfg_data;
      end else if (cfg_index == REG_LINE_LENGTH) begin
        line_len_r <= cfg_data[LEN_W-1:0];
      end
    end
  end

  sfm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel_in (in_pixel_in),
    .in_line_end (in_line_end),
    .line_length (line_len_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  sfm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  sfm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .coef               (coef_r),
    .q_valid            (q_valid),
    .q_job              (head_job),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_raw   (out_filtered_raw),
    .out_filtered_pixel (out_filtered_pixel),
    .out_last           (out_last)
  );

  // Queue never takes a job while full
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Back end only pops a job that is there
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // Reset drains the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule : symmetric_fir11_mirror_line_core
`default_nettype wire

@@ verif/symmetric_fir11_mirror_line_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_fir11_mirror_line_core_test: self-checking bench of the line filter
// Streams pixel lines through the core under many coefficient and line length
// settings, predicts every filtered output in the bench and compares each
// output transaction field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module symmetric_fir11_mirror_line_core_test;
  import sfm_pkg::*;

  localparam int IDLE_MAX      = 13;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RAND_ITEMS    = 125;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw;
    logic [PIX_W-1:0]        pixel;
    logic                    last;
  } filter_out_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [PIX_W-1:0]       in_pixel_in;
  logic                   in_line_end;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [RAW_W-1:0] out_filtered_raw;
  logic [PIX_W-1:0]       out_filtered_pixel;
  logic                   out_last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DAT_W-1:0]   cfg_data;

  // Bench copy of the filter state and registers
  logic signed [COEF_W-1:0] coef_shadow [NUM_COEF];
  logic [LEN_W-1:0]         line_len_shadow;
  logic [PIX_W-1:0]         window_shadow [TAPS];
  int                       position_shadow;

  filter_out_t expected_filter_out [$];

  bit idle_on;
  int error_count;
  int outputs_checked;
  int pixels_sent;
  int lines_closed;
  int register_writes;
  int cycle_count;

  symmetric_fir11_mirror_line_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_in       (in_pixel_in),
    .in_line_end       (in_line_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_filtered_raw  (out_filtered_raw),
    .out_filtered_pixel(out_filtered_pixel),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Reset state of the bench copy
  function automatic void reset_shadow();
    coef_shadow[0] = COEF_ONE;
    for (int a = 1; a < NUM_COEF; a++) coef_shadow[a] = '0;
    line_len_shadow = LINE_LEN_RESET;
    for (int i = 0; i < TAPS; i++) window_shadow[i] = '0;
    position_shadow = 0;
  endfunction

  // Mirror the register write into the bench copy
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_COEF_CENTRE, REG_COEF_OFF1, REG_COEF_OFF2,
      REG_COEF_OFF3, REG_COEF_OFF4, REG_COEF_OFF5: begin
        coef_shadow[idx - REG_COEF_CENTRE] = data[COEF_W-1:0];
      end
      REG_LINE_LENGTH: begin
        line_len_shadow = data[LEN_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // Filter sum for centre sample c, newest stored sample p, line of n so far
  function automatic filter_out_t filter_sample(input int c, input int p, input int n,
                                                input logic last);
    longint      acc;
    longint      rounded;
    int          k;
    int          d;
    int          a;
    filter_out_t r;
    acc = 0;
    for (int t = -HALF_TAPS; t <= HALF_TAPS; t++) begin
      // reflect around the edge sample, clamp what is still outside
      k = c + t;
      if (k < 0) k = -k;
      if (k > n - 1) k = 2 * (n - 1) - k;
      if (k < 0) k = 0;
      d = p - k;
      if (d < 0) d = 0;
      if (d > TAPS - 1) d = TAPS - 1;
      a = (t < 0) ? -t : t;
      acc += longint'(coef_shadow[a]) * longint'(window_shadow[d]);
    end
    r.raw = acc[RAW_W-1:0];
    if (acc < 0) begin
      r.pixel = '0;
    end else begin
      rounded = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      r.pixel = (rounded > 255) ? 8'd255 : rounded[PIX_W-1:0];
    end
    r.last = last;
    return r;
  endfunction

  // Advance the window by one accepted pixel and queue the outputs it releases
  function automatic void predict_line_pixel(input logic [PIX_W-1:0] px, input logic le);
    int eff;
    int p;
    int n;
    int first;
    bit ends;
    for (int i = TAPS - 1; i > 0; i--) window_shadow[i] = window_shadow[i-1];
    window_shadow[0] = px;
    eff = line_len_shadow;
    if (eff == 0 || eff > MAX_LINE) eff = MAX_LINE;
    p = position_shadow;
    n = p + 1;
    ends = le || (n >= eff);
    if (!ends) begin
      position_shadow = n;
      if (p >= HALF_TAPS) expected_filter_out.push_back(filter_sample(p - HALF_TAPS, p, n, 1'b0));
    end else begin
      // flush the outstanding outputs of the line
      first = (p >= HALF_TAPS) ? p - HALF_TAPS : 0;
      for (int c = first; c <= p; c++)
        expected_filter_out.push_back(filter_sample(c, p, n, c == p));
      position_shadow = 0;
      lines_closed++;
    end
  endfunction

  // Send one pixel transaction after a random gap
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic le);
    int gap;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    in_line_end <= le;
    do @(posedge clk); while (!in_ready);
    predict_line_pixel(px, le);
    pixels_sent++;
  endtask

  // Write one register, only while the core is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    register_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_coefs(input logic [COEF_W-1:0] c0, input logic [COEF_W-1:0] c1,
                             input logic [COEF_W-1:0] c2, input logic [COEF_W-1:0] c3,
                             input logic [COEF_W-1:0] c4, input logic [COEF_W-1:0] c5);
    write_register(REG_COEF_CENTRE, c0);
    write_register(REG_COEF_OFF1, c1);
    write_register(REG_COEF_OFF2, c2);
    write_register(REG_COEF_OFF3, c3);
    write_register(REG_COEF_OFF4, c4);
    write_register(REG_COEF_OFF5, c5);
  endtask

  // Hold off the sender until every expected output has come, then settle
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_filter_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset coefficients pass pixels through unchanged
  task automatic test_reset_passthrough();
    logic [PIX_W-1:0] line_px [6];
    line_px = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd254, 8'd1};
    idle_on = 1'b1;
    for (int i = 0; i < 6; i++) send_pixel(line_px[i], i == 5);
    drain_outputs();
  endtask

  // Half-weight centre rounds half up; a strong edge tap shows mirroring on short lines
  task automatic test_short_lines_rounding();
    int lens [3];
    lens = '{1, 2, 4};
    write_coefs(COEF_W'(8192), '0, '0, '0, '0, COEF_ONE);
    idle_on = 1'b0;
    foreach (lens[j]) begin
      for (int i = 0; i < lens[j]; i++)
        send_pixel(PIX_W'(2 * $urandom_range(0, 127) + 1), i == lens[j] - 1);
    end
    drain_outputs();
  endtask

  // Full-scale coefficients: clip at 255 and at 0
  task automatic test_extreme_coefs();
    write_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    idle_on = 1'b1;
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);
    drain_outputs();
    write_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);
    drain_outputs();
  endtask

  // Line length of 11: the line closes by count without a line end flag
  task automatic test_length_end();
    write_coefs(COEF_W'(6144), COEF_W'(3072), COEF_W'(1024), COEF_W'(512),
                COEF_W'(256), COEF_W'(-1024));
    write_register(REG_LINE_LENGTH, CFG_DAT_W'(11));
    idle_on = 1'b1;
    for (int i = 0; i < 12; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
    send_pixel(PIX_W'($urandom_range(0, 255)), 1'b1);
    drain_outputs();
  endtask

  // Random lines under random register settings
  task automatic test_random_lines();
    int                          sent;
    int                          len;
    int                          mode;
    int                          lowpass_sum;
    logic [COEF_W-1:0]           c [NUM_COEF];
    logic [LEN_W-1:0]            line_len;
    logic [CFG_DAT_W-LEN_W-1:0]  len_hi;
    logic [PIX_W-1:0]            px;
    logic                        le;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      // pick a coefficient set
      mode = $urandom_range(0, 3);
      lowpass_sum = 0;
      for (int a = NUM_COEF - 1; a >= 0; a--) begin
        case (mode)
          0: c[a] = COEF_W'($urandom);
          1: begin
            case ($urandom_range(0, 2))
              0: c[a] = 16'h8000;
              1: c[a] = 16'h7FFF;
              default: c[a] = '0;
            endcase
          end
          default: begin
            if (a > 0) begin
              c[a] = COEF_W'($urandom_range(0, 3000));
              lowpass_sum += c[a];
            end else begin
              c[a] = COEF_W'(16384 - 2 * lowpass_sum);
            end
          end
        endcase
      end
      write_coefs(c[0], c[1], c[2], c[3], c[4], c[5]);
      // pick a line length, upper data bits random
      case ($urandom_range(0, 5))
        0: line_len = '0;
        1: line_len = '1;
        2: line_len = LEN_W'(11);
        3: line_len = LEN_W'(MAX_LINE);
        default: line_len = LEN_W'($urandom_range(11, 40));
      endcase
      len_hi = (CFG_DAT_W-LEN_W)'($urandom);
      write_register(REG_LINE_LENGTH, {len_hi, line_len});
      // stream lines, a few broken by an early line end
      for (int item = 0; item < 25; item++) begin
        if (item % 8 == 0) idle_on = ($urandom_range(0, 3) != 0);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 30);
        for (int i = 0; i < len && item < 25; i++) begin
          case ($urandom_range(0, 7))
            0: px = '0;
            1: px = '1;
            default: px = PIX_W'($urandom);
          endcase
          le = (i == len - 1) || (item == 24) || ($urandom_range(0, 19) == 0);
          send_pixel(px, le);
          sent++;
          if (i < len - 1) item++;
        end
      end
      drain_outputs();
    end
  endtask

  // Receiver: random stall before each output transaction
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    filter_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_filter_out.size() == 0) begin
        $display("%0t: unexpected output raw=%0d pixel=%0d last=%0b",
                 $time, out_filtered_raw, out_filtered_pixel, out_last);
        error_count++;
      end else begin
        want = expected_filter_out.pop_front();
        if (out_filtered_raw !== want.raw) begin
          $display("%0t: filtered_raw expected %0d actual %0d", $time, want.raw,
                   out_filtered_raw);
          error_count++;
        end
        if (out_filtered_pixel !== want.pixel) begin
          $display("%0t: filtered_pixel expected %0d actual %0d", $time, want.pixel,
                   out_filtered_pixel);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
          error_count++;
        end
        outputs_checked++;
      end
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout, %0d outputs still expected", $time, expected_filter_out.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    in_line_end = 1'b0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_COEF_CENTRE;
    cfg_data    = '0;
    idle_on     = 1'b1;
    error_count = 0;
    outputs_checked = 0;
    pixels_sent     = 0;
    lines_closed    = 0;
    register_writes = 0;
    reset_shadow();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_passthrough();
    test_short_lines_rounding();
    test_extreme_coefs();
    test_length_end();
    test_random_lines();

    if (expected_filter_out.size() != 0) begin
      $display("%0t: %0d outputs never arrived", $time, expected_filter_out.size());
      error_count++;
    end
    $display("Sent %0d pixels in %0d lines, checked %0d outputs, %0d register writes.",
             pixels_sent, lines_closed, outputs_checked, register_writes);
    $display("Covered short and length-closed lines, clipping, rounding, idle and stall.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
